@@ design/tce_pkg.sv @@
// Shared types, constants and helper functions for the text console cell engine.
// No dependencies; the controller, datapath and top refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tce_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_WIDTH  = 8;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    // last destination row start of the scroll copy; blanking starts here
    localparam int COPY_LAST  = CELL_COUNT - COLUMNS;
    // enough tab stops to cover any 7-bit column
    localparam int TAB_STOPS  = 128 / TAB_WIDTH + 1;

    localparam logic [15:0] BLANK_CELL = 16'h0F20;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SET   = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [7:0]  char_code;
        logic [3:0]  bg_color;
        logic [3:0]  fg_color;
        logic [10:0] cell_index;
        logic [6:0]  new_column;
        logic [4:0]  new_row;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_addr;
        logic        scrolled;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic take;
        logic exec;
        logic copy;
        logic blank;
        logic load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_opcode op;
        logic    scroll_need;
        logic    copy_last;
        logic    blank_last;
        logic    out_free;
    } t_status;

    // next multiple of TAB_WIDTH strictly above the column
    function automatic logic [7:0] next_tab(input logic [6:0] col);
        logic [7:0] r;
        r = '0;
        for (int k = TAB_STOPS; k >= 1; k--) begin
            if (k * TAB_WIDTH > int'(col)) begin
                r = 8'(k * TAB_WIDTH);
            end
        end
        return r;
    endfunction

    function automatic logic [10:0] cell_loc(input logic [4:0] row, input logic [6:0] col);
        return 11'(int'(row) * COLUMNS + int'(col));
    endfunction

endpackage

`default_nettype wire

@@ design/tce_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ design/tce_ctrl.sv @@
// Sequencer for the console engine: reset blanking, item execution, scroll
// copy, screen blanking and result hand-off. Uses tce_pkg command/status types.
`timescale 1ns / 1ps
`default_nettype none

module tce_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire tce_pkg::t_status i_status,
    output tce_pkg::t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_COPY,
        S_BLANK,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   ready;

    always_comb begin
        ready = (r_state == S_IDLE) || ((r_state == S_RESULT) && i_status.out_free);
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.take  = ready && i_valid;
        o_cmd.exec  = (r_state == S_EXEC);
        o_cmd.copy  = (r_state == S_COPY);
        o_cmd.blank = (r_state == S_BLANK) || (r_state == S_INIT);
        o_cmd.load  = (r_state == S_RESULT) && i_status.out_free;
        o_stall     = !ready;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_status.blank_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (i_status.op)
                    tce_pkg::OP_PUT:   n_state = i_status.scroll_need ? S_COPY : S_RESULT;
                    tce_pkg::OP_CLEAR: n_state = S_BLANK;
                    tce_pkg::OP_READ,
                    tce_pkg::OP_SET:   n_state = S_RESULT;
                    default:           n_state = S_RESULT;
                endcase
            end
            S_COPY: begin
                if (i_status.copy_last) n_state = S_BLANK;
            end
            S_BLANK: begin
                if (i_status.blank_last) n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_status.out_free) n_state = i_valid ? S_EXEC : S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // no item may enter while the reset blanking pass runs
    a_no_take_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_cmd.take)
        else $error("item taken during reset blanking");

    // a scroll must always pass through the blanking of the bottom row
    a_copy_to_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) && i_status.copy_last |=> (r_state == S_BLANK))
        else $error("scroll copy did not continue into blanking");

    // execution follows exactly one take
    a_exec_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $past(o_cmd.take))
        else $error("execute without a taken item");

endmodule

`default_nettype wire

@@ design/tce_datapath.sv @@
// Datapath of the console engine: item register, cursor, screen RAM ports,
// sweep counter for blanking and scroll copy, and the output register.
// Uses tce_pkg and tce_ram.
`timescale 1ns / 1ps
`default_nettype none

module tce_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tce_pkg::t_in_item i_item,
    input  wire logic              i_stall,
    input  wire tce_pkg::t_cmd     i_cmd,
    output tce_pkg::t_status       o_status,
    output logic                   o_valid,
    output tce_pkg::t_out_item     o_item
);

    tce_pkg::t_in_item  r_item;
    tce_pkg::t_out_item r_out;
    logic               r_out_valid;
    logic [6:0]         r_col;
    logic [4:0]         r_row;
    logic               r_scrolled;
    logic [tce_pkg::ADDR_W:0] r_sweep;

    logic [7:0]  put_col;
    logic [5:0]  put_row;
    logic        printable;
    logic        scroll_need;
    logic        idx_ok;
    logic        out_free;

    logic                      wr_en;
    logic [tce_pkg::ADDR_W-1:0] wr_addr;
    logic [15:0]               wr_data;
    logic [tce_pkg::ADDR_W-1:0] rd_addr;
    logic [15:0]               rd_data;

    // cursor motion for a put, before wrap and scroll
    always_comb begin
        logic [7:0] c;
        logic [5:0] r;
        c         = {1'b0, r_col};
        r         = {1'b0, r_row};
        printable = 1'b0;
        unique case (r_item.char_code)
            tce_pkg::CH_BS: begin
                if (r_col != '0) c = c - 8'd1;
            end
            tce_pkg::CH_TAB: begin
                c = tce_pkg::next_tab(r_col);
            end
            tce_pkg::CH_CR: begin
                c = '0;
            end
            tce_pkg::CH_LF: begin
                c = '0;
                r = r + 6'd1;
            end
            default: begin
                if (!r_item.char_code[7] && (r_item.char_code >= tce_pkg::CH_SPACE)) begin
                    printable = 1'b1;
                    c         = c + 8'd1;
                end
            end
        endcase
        if (int'(c) >= tce_pkg::COLUMNS) begin
            c = '0;
            r = r + 6'd1;
        end
        put_col     = c;
        put_row     = r;
        scroll_need = (int'(r) >= tce_pkg::ROWS);
    end

    always_comb begin
        idx_ok   = (int'(r_item.cell_index) < tce_pkg::CELL_COUNT);
        out_free = !r_out_valid || !i_stall;
    end

    // RAM port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_sweep[tce_pkg::ADDR_W-1:0];
        wr_data = tce_pkg::BLANK_CELL;
        if (i_cmd.blank) begin
            wr_en = 1'b1;
        end else if (i_cmd.copy) begin
            wr_en   = (r_sweep != '0);
            wr_addr = tce_pkg::ADDR_W'(r_sweep - 1'b1);
            wr_data = rd_data;
        end else if (i_cmd.exec && (r_item.opcode == tce_pkg::OP_PUT) && printable) begin
            wr_en   = 1'b1;
            wr_addr = tce_pkg::ADDR_W'(tce_pkg::cell_loc(r_row, r_col));
            wr_data = {r_item.bg_color, r_item.fg_color, r_item.char_code};
        end

        if (i_cmd.copy && (int'(r_sweep) < tce_pkg::COPY_LAST)) begin
            rd_addr = tce_pkg::ADDR_W'(int'(r_sweep) + tce_pkg::COLUMNS);
        end else if (idx_ok) begin
            // hold the item's address so the read data stays put while stalled
            rd_addr = tce_pkg::ADDR_W'(r_item.cell_index);
        end else begin
            rd_addr = '0;
        end
    end

    tce_ram #(
        .WIDTH (16),
        .DEPTH (tce_pkg::CELL_COUNT)
    ) u_screen (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item <= i_item;
        end
        if (i_cmd.load) begin
            r_out.cell_data     <= ((r_item.opcode == tce_pkg::OP_READ) && idx_ok) ?
                                   rd_data : 16'd0;
            r_out.cursor_column <= r_col;
            r_out.cursor_row    <= r_row;
            r_out.cursor_addr   <= tce_pkg::cell_loc(r_row, r_col);
            r_out.scrolled      <= r_scrolled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_scrolled  <= 1'b0;
            r_sweep     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.exec) begin
                r_scrolled <= 1'b0;
                unique case (r_item.opcode)
                    tce_pkg::OP_PUT: begin
                        r_col      <= put_col[6:0];
                        r_row      <= scroll_need ? 5'(tce_pkg::ROWS - 1) : put_row[4:0];
                        r_scrolled <= scroll_need;
                        if (scroll_need) r_sweep <= '0;
                    end
                    tce_pkg::OP_READ: begin
                    end
                    tce_pkg::OP_CLEAR: begin
                        r_col   <= '0;
                        r_row   <= '0;
                        r_sweep <= '0;
                    end
                    tce_pkg::OP_SET: begin
                        r_col <= (int'(r_item.new_column) < tce_pkg::COLUMNS) ?
                                 r_item.new_column : 7'(tce_pkg::COLUMNS - 1);
                        r_row <= (int'(r_item.new_row) < tce_pkg::ROWS) ?
                                 r_item.new_row : 5'(tce_pkg::ROWS - 1);
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.copy) begin
                // hold at the last copy slot so blanking starts on the bottom row
                if (int'(r_sweep) != tce_pkg::COPY_LAST) r_sweep <= r_sweep + 1'b1;
            end else if (i_cmd.blank) begin
                r_sweep <= r_sweep + 1'b1;
            end
        end
    end

    always_comb begin
        o_status.op          = r_item.opcode;
        o_status.scroll_need = scroll_need;
        o_status.copy_last   = (int'(r_sweep) == tce_pkg::COPY_LAST);
        o_status.blank_last  = (int'(r_sweep) == tce_pkg::CELL_COUNT - 1);
        o_status.out_free    = out_free;
        o_valid              = r_out_valid;
        o_item               = r_out;
    end

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_col) < tce_pkg::COLUMNS) && (int'(r_row) < tce_pkg::ROWS))
        else $error("cursor outside the screen");

    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.scrolled |-> (int'(r_out.cursor_row) == tce_pkg::ROWS - 1))
        else $error("scrolled result not on the bottom row");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> out_free)
        else $error("result loaded over an untaken beat");

    a_wr_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (i_cmd.blank || i_cmd.copy || i_cmd.exec))
        else $error("screen write outside a write phase");

endmodule

`default_nettype wire

@@ design/text_console_cell_engine_top.sv @@
// Top level of the text console cell engine: controller plus datapath.
// Depends on tce_pkg, tce_ctrl, tce_datapath (and tce_ram through it).
`timescale 1ns / 1ps
`default_nettype none

// Keeps an 80x25 screen of 16-bit cells (attribute high byte, character low
// byte) in one RAM with one write and one registered read port, plus a
// cursor. Each input beat carries one command and yields one result beat.
// Put character, read cell and set cursor run back to back through execute
// and result states: the item is taken, executed, and its result registered
// at the same edge the next item is taken, while the output register is
// free. A put that scrolls adds a row copy and a bottom-row blanking, one
// cell per cycle through the RAM ports; a clear blanks all 2000 cells.
// After reset the block blanks all 2000 cells and stalls input until done.
// The result register lets one more item in while a result waits.
module text_console_cell_engine_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire tce_pkg::t_in_item  i_item,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output tce_pkg::t_out_item      o_item
);

    tce_pkg::t_cmd    cmd;
    tce_pkg::t_status status;

    tce_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tce_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_stall  (i_stall),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_valid),
        .o_item   (o_item)
    );

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for text_console_cell_engine_top: directed and random commands
// are checked against an in-bench shadow screen and cursor. Depends on tce_pkg.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [7:0] CH_LAST_PRINT = 8'h7F;
    localparam int         LONG_HOLD     = 400;
    localparam int         DRAIN_CYCLES  = 20;
    localparam int         IN_W          = $bits(tce_pkg::t_in_item);

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    tce_pkg::t_in_item  in_item   = '0;
    logic               out_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    tce_pkg::t_out_item o_item;

    // shadow of the block's screen and cursor
    logic [15:0] shadow_screen [tce_pkg::CELL_COUNT];
    int          cur_col;
    int          cur_row;

    tce_pkg::t_out_item pending_results [$];
    int          fail_count  = 0;
    int          op_tally [4] = '{default: 0};
    int          scroll_tally = 0;
    bit          steady_flow  = 1'b0;
    int          holds_asked  = 0;

    text_console_cell_engine_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (o_stall),
        .i_item  (in_item),
        .o_valid (o_valid),
        .i_stall (out_stall),
        .o_item  (o_item)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic console_step(input tce_pkg::t_in_item cmd,
                                output tce_pkg::t_out_item res);
        logic [7:0] ch;
        res = '0;
        ch  = cmd.char_code;
        case (cmd.opcode)
            tce_pkg::OP_PUT: begin
                if (ch == tce_pkg::CH_BS) begin
                    if (cur_col != 0) cur_col--;
                end else if (ch == tce_pkg::CH_TAB) begin
                    cur_col = cur_col + tce_pkg::TAB_WIDTH - cur_col % tce_pkg::TAB_WIDTH;
                end else if (ch == tce_pkg::CH_CR) begin
                    cur_col = 0;
                end else if (ch == tce_pkg::CH_LF) begin
                    cur_col = 0;
                    cur_row++;
                end else if (ch >= tce_pkg::CH_SPACE && ch <= CH_LAST_PRINT) begin
                    shadow_screen[cur_row * tce_pkg::COLUMNS + cur_col] =
                        {cmd.bg_color, cmd.fg_color, ch};
                    cur_col++;
                end
                if (cur_col >= tce_pkg::COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= tce_pkg::ROWS) begin
                    for (int i = 0; i < tce_pkg::CELL_COUNT - tce_pkg::COLUMNS; i++)
                        shadow_screen[i] = shadow_screen[i + tce_pkg::COLUMNS];
                    for (int i = tce_pkg::CELL_COUNT - tce_pkg::COLUMNS;
                         i < tce_pkg::CELL_COUNT; i++)
                        shadow_screen[i] = tce_pkg::BLANK_CELL;
                    cur_row      = tce_pkg::ROWS - 1;
                    res.scrolled = 1'b1;
                end
            end
            tce_pkg::OP_READ: begin
                if (int'(cmd.cell_index) < tce_pkg::CELL_COUNT)
                    res.cell_data = shadow_screen[cmd.cell_index];
            end
            tce_pkg::OP_CLEAR: begin
                for (int i = 0; i < tce_pkg::CELL_COUNT; i++)
                    shadow_screen[i] = tce_pkg::BLANK_CELL;
                cur_col = 0;
                cur_row = 0;
            end
            default: begin
                cur_col = (int'(cmd.new_column) < tce_pkg::COLUMNS) ?
                          int'(cmd.new_column) : tce_pkg::COLUMNS - 1;
                cur_row = (int'(cmd.new_row) < tce_pkg::ROWS) ?
                          int'(cmd.new_row) : tce_pkg::ROWS - 1;
            end
        endcase
        res.cursor_column = 7'(cur_col);
        res.cursor_row    = 5'(cur_row);
        res.cursor_addr   = 11'(cur_row * tce_pkg::COLUMNS + cur_col);
    endtask

    // Hold the beat until taken, then predict its result. Valid stays high on return.
    task automatic push_command(input tce_pkg::t_in_item cmd);
        tce_pkg::t_out_item res;
        if (!steady_flow) begin
            while ($urandom_range(99) < 15) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= cmd;
        do @(posedge clk); while (o_stall);
        console_step(cmd, res);
        pending_results.push_back(res);
        op_tally[cmd.opcode]++;
        if (res.scrolled) scroll_tally++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    function automatic tce_pkg::t_in_item put_cmd(logic [7:0] ch, logic [3:0] back,
                                                  logic [3:0] fore);
        tce_pkg::t_in_item c;
        c           = '0;
        c.opcode    = tce_pkg::OP_PUT;
        c.char_code = ch;
        c.bg_color  = back;
        c.fg_color  = fore;
        return c;
    endfunction

    function automatic tce_pkg::t_in_item read_cmd(int idx);
        tce_pkg::t_in_item c;
        c            = '0;
        c.opcode     = tce_pkg::OP_READ;
        c.cell_index = 11'(idx);
        return c;
    endfunction

    function automatic tce_pkg::t_in_item set_cmd(int col, int row);
        tce_pkg::t_in_item c;
        c            = '0;
        c.opcode     = tce_pkg::OP_SET;
        c.new_column = 7'(col);
        c.new_row    = 5'(row);
        return c;
    endfunction

    // Mostly printable text with a sprinkling of controls, reads, moves and rare clears.
    function automatic tce_pkg::t_in_item random_command();
        logic [IN_W-1:0] raw;
        tce_pkg::t_in_item c;
        int pick;
        raw  = IN_W'({$urandom(), $urandom()});
        c    = raw;
        pick = $urandom_range(99);
        if (pick < 55) begin
            c.opcode    = tce_pkg::OP_PUT;
            c.char_code = 8'($urandom_range(tce_pkg::CH_SPACE, CH_LAST_PRINT));
        end else if (pick < 62) begin
            c.opcode = tce_pkg::OP_PUT;
            case ($urandom_range(3))
                0:       c.char_code = tce_pkg::CH_BS;
                1:       c.char_code = tce_pkg::CH_TAB;
                2:       c.char_code = tce_pkg::CH_CR;
                default: c.char_code = tce_pkg::CH_LF;
            endcase
        end else if (pick < 67) begin
            c.opcode = tce_pkg::OP_PUT;
        end else if (pick < 82) begin
            c.opcode = tce_pkg::OP_READ;
            case ($urandom_range(3))
                0: c.cell_index = 11'($urandom_range(2047, tce_pkg::CELL_COUNT));
                1: c.cell_index = 11'((cur_row * tce_pkg::COLUMNS + cur_col
                                       + tce_pkg::CELL_COUNT - 1) % tce_pkg::CELL_COUNT);
                default: c.cell_index = 11'($urandom_range(tce_pkg::CELL_COUNT - 1));
            endcase
        end else if (pick < 83) begin
            c.opcode = tce_pkg::OP_CLEAR;
        end else begin
            c.opcode = tce_pkg::OP_SET;
        end
        return c;
    endfunction

    task automatic test_reset_contents();
        push_command(read_cmd(tce_pkg::CELL_COUNT - 1));
        push_command(read_cmd(tce_pkg::CELL_COUNT));
        push_command(read_cmd(2047));
    endtask

    task automatic test_cursor_controls();
        push_command(put_cmd(tce_pkg::CH_BS, 4'h0, 4'h0));
        push_command(put_cmd(CH_LAST_PRINT, 4'hF, 4'h0));
        push_command(put_cmd(tce_pkg::CH_SPACE, 4'h0, 4'hF));
        push_command(put_cmd(tce_pkg::CH_BS, 4'h0, 4'h0));
        push_command(put_cmd(tce_pkg::CH_TAB, 4'h0, 4'h0));
        push_command(put_cmd(tce_pkg::CH_TAB, 4'h0, 4'h0));
        push_command(put_cmd(tce_pkg::CH_CR, 4'h0, 4'h0));
        push_command(put_cmd(8'hFF, 4'hF, 4'hF));
        push_command(put_cmd(8'h00, 4'hF, 4'hF));
        push_command(put_cmd(tce_pkg::CH_LF, 4'h0, 4'h0));
        push_command(read_cmd(0));
        push_command(read_cmd(1));
    endtask

    task automatic test_wrap_and_scroll();
        // out-of-range target saturates to the bottom-right cell
        push_command(set_cmd(127, 31));
        push_command(put_cmd(8'h5A, 4'h1, 4'hE));
        push_command(read_cmd(tce_pkg::CELL_COUNT - tce_pkg::COLUMNS - 1));
        push_command(set_cmd(tce_pkg::COLUMNS - 4, tce_pkg::ROWS - 1));
        push_command(put_cmd(tce_pkg::CH_TAB, 4'h0, 4'h0));
        push_command(set_cmd(5, tce_pkg::ROWS - 1));
        push_command(put_cmd(tce_pkg::CH_LF, 4'h0, 4'h0));
        push_command(set_cmd(tce_pkg::COLUMNS - 1, 0));
        push_command(put_cmd(8'h41, 4'h2, 4'h7));
    endtask

    task automatic test_clear();
        push_command(tce_pkg::t_in_item'{opcode: tce_pkg::OP_CLEAR, default: '0});
        push_command(read_cmd(tce_pkg::CELL_COUNT - tce_pkg::COLUMNS - 1));
    endtask

    // Hold off the output while commands keep coming, then let everything drain.
    task automatic test_output_hold();
        holds_asked++;
        repeat (24) push_command(random_command());
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int count, input bit no_gaps);
        steady_flow = no_gaps;
        repeat (count) push_command(random_command());
        steady_flow = 1'b0;
    endtask

    initial begin : result_sink
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(posedge clk);
            if (holds_asked != holds_served) begin
                holds_served = holds_asked;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !steady_flow && ($urandom_range(99) < 15);
            end
        end
    end

    always @(posedge clk) begin
        tce_pkg::t_out_item want;
        if (rst_n && o_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no command outstanding: %h", o_item);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_item.cell_data !== want.cell_data) begin
                    $error("cell_data expected %h got %h", want.cell_data, o_item.cell_data);
                    fail_count++;
                end
                if (o_item.cursor_column !== want.cursor_column) begin
                    $error("cursor_column expected %0d got %0d",
                           want.cursor_column, o_item.cursor_column);
                    fail_count++;
                end
                if (o_item.cursor_row !== want.cursor_row) begin
                    $error("cursor_row expected %0d got %0d", want.cursor_row, o_item.cursor_row);
                    fail_count++;
                end
                if (o_item.cursor_addr !== want.cursor_addr) begin
                    $error("cursor_addr expected %0d got %0d",
                           want.cursor_addr, o_item.cursor_addr);
                    fail_count++;
                end
                if (o_item.scrolled !== want.scrolled) begin
                    $error("scrolled expected %b got %b", want.scrolled, o_item.scrolled);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #100_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < tce_pkg::CELL_COUNT; i++) shadow_screen[i] = tce_pkg::BLANK_CELL;
        cur_col = 0;
        cur_row = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_contents();
        test_cursor_controls();
        test_wrap_and_scroll();
        test_clear();
        test_output_hold();
        test_random_traffic(300, 1'b1);
        test_random_traffic(800, 1'b0);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d commands: %0d puts, %0d reads, %0d clears, %0d cursor moves",
                 op_tally.sum(),
                 op_tally[tce_pkg::OP_PUT], op_tally[tce_pkg::OP_READ],
                 op_tally[tce_pkg::OP_CLEAR], op_tally[tce_pkg::OP_SET]);
        $display("%0d scrolls seen, plus a long output hold and a full input drain",
                 scroll_tally);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/tce_pkg.sv
design/tce_ram.sv
design/tce_ctrl.sv
design/tce_datapath.sv
design/text_console_cell_engine_top.sv
bench/tb_top.sv
